@@ rtl/s2x_pkg.sv @@
package s2x_pkg;

   localparam int MAX_WIDTH_DEF  = 128;
   localparam int MAX_HEIGHT_DEF = 64;

   localparam int WIDTH_RESET  = 64;
   localparam int HEIGHT_RESET = 32;

   localparam int CSR_DATA_W = 8;
   localparam int COL_OUT_W  = 7;
   localparam int ROW_OUT_W  = 6;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic e;
      logic b;
      logic d;
      logic f;
      logic h;
   } nbr_type;

   typedef struct packed {
      logic top_left;
      logic top_right;
      logic bottom_left;
      logic bottom_right;
   } blk_type;

endpackage

@@ rtl/scale2x_pixel_upscaler.sv @@
// The word for a pixel is registered at the push of the pixel one row plus one place
// later, or at the drain word that flushes it. Throughput: one word per cycle unless
// stalled, set by the pixel shift line that advances once per word.
// After the last push of a frame one pixel high, input is held off while the line pads.
// Synchronous active-high reset clears the counters and the output valid and loads
// the frame size registers with 64 by 32, clamped to the maximum size.
module scale2x_pixel_upscaler
   import s2x_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic                  req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_top_left,
   output logic                  rsp_top_right,
   output logic                  rsp_bottom_left,
   output logic                  rsp_bottom_right,
   output logic [COL_OUT_W-1:0]  rsp_src_col,
   output logic [ROW_OUT_W-1:0]  rsp_src_row,
   output logic                  rsp_last_of_frame,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   function automatic int clamp_m1(input int v, input int mx);
      int r;
      if (v == 0) begin
         r = 0;
      end else if (v > mx) begin
         r = mx - 1;
      end else begin
         r = v - 1;
      end
      return r;
   endfunction

   logic [CW-1:0] wm1_ff, wm1_in;
   logic [RW-1:0] hm1_ff, hm1_in;
   logic [CW-1:0] ax_ff, ax_in;
   logic [RW-1:0] ay_ff, ay_in;
   logic [CW-1:0] ex_ff, ex_in;
   logic [RW-1:0] ey_ff, ey_in;
   logic          full_ff, full_in;
   logic          done_ff, done_in;
   logic          pad_ff, pad_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          p0_ff, p0_in;
   logic          pc_ff, pc_in;
   logic          pd_ff, pd_in;

   blk_type                blk_ff;
   logic [COL_OUT_W-1:0]   col_ff;
   logic [ROW_OUT_W-1:0]   row_ff;
   logic                   last_ff;

   logic          is_push, req_fire, restart;
   logic [CW-1:0] ax0, ex0;
   logic [RW-1:0] ay0, ey0;
   logic          done0, primed, push_go, drain_go, emit, shift, last;
   logic          pf, pb;
   nbr_type       nbr;
   blk_type       blk;

   s2x_line #(.DEPTH(MAX_WIDTH - 1)) u_line_a (
      .clock    (clock),
      .shift    (shift),
      .len      (wm1_ff),
      .data_in  (p0_ff),
      .data_out (pf)
   );

   s2x_line #(.DEPTH(MAX_WIDTH - 1)) u_line_b (
      .clock    (clock),
      .shift    (shift),
      .len      (wm1_ff),
      .data_in  (pd_ff),
      .data_out (pb)
   );

   s2x_blend u_blend (
      .nbr (nbr),
      .blk (blk)
   );

   always_comb begin
      req_stall = (rsp_valid_ff & rsp_stall) | pad_ff;
      req_fire  = req_valid & ~req_stall;
      is_push   = (req_cmd == CMD_PUSH);
      restart   = is_push & full_ff & done_ff;
      ax0       = restart ? '0 : ax_ff;
      ay0       = restart ? '0 : ay_ff;
      ex0       = restart ? '0 : ex_ff;
      ey0       = restart ? '0 : ey_ff;
      done0     = done_ff & ~restart;
      primed    = (ay0 > RW'(1)) | ((ay0 == RW'(1)) & (ax0 != '0));
      push_go   = req_fire & is_push & (~full_ff | done_ff);
      drain_go  = req_fire & (req_cmd == CMD_DRAIN) & full_ff & ~done_ff;
      emit      = (push_go & primed & ~done0) | drain_go;
      shift     = push_go | drain_go | pad_ff;
      last      = (ex0 == wm1_ff) & (ey0 == hm1_ff);

      nbr.e = pc_ff;
      nbr.b = (ey0 == '0) ? pc_ff : pb;
      nbr.d = (ex0 == '0) ? pc_ff : pd_ff;
      nbr.f = (ex0 == wm1_ff) ? pc_ff : pf;
      nbr.h = (ey0 == hm1_ff) ? pc_ff : p0_ff;

      p0_in = push_go ? req_pixel_in : 1'b0;
      pc_in = pf;
      pd_in = pc_ff;

      wm1_in  = wm1_ff;
      hm1_in  = hm1_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      ex_in   = ex_ff;
      ey_in   = ey_ff;
      full_in = full_ff;
      done_in = done_ff;
      pad_in  = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  wm1_in = CW'(clamp_m1(int'(csr_wdata), MAX_WIDTH));
            CSR_FRAME_HEIGHT: hm1_in = RW'(clamp_m1(int'(csr_wdata[6:0]), MAX_HEIGHT));
            default:          wm1_in = wm1_ff;
         endcase
         ax_in   = '0;
         ay_in   = '0;
         ex_in   = '0;
         ey_in   = '0;
         full_in = 1'b0;
         done_in = 1'b0;
      end else begin
         if (push_go) begin
            ax_in   = (ax0 == wm1_ff) ? '0 : ax0 + CW'(1);
            ay_in   = (ax0 == wm1_ff) ? ay0 + RW'(1) : ay0;
            full_in = (ax0 == wm1_ff) & (ay0 == hm1_ff);
            // A one-row frame is one shift short of the drain alignment.
            pad_in  = full_in & (hm1_ff == '0);
            ex_in   = ex0;
            ey_in   = ey0;
            done_in = done0;
         end
         if (emit) begin
            ex_in   = (ex0 == wm1_ff) ? '0 : ex0 + CW'(1);
            ey_in   = (ex0 == wm1_ff) ? ey0 + RW'(1) : ey0;
            done_in = last;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff       <= CW'(clamp_m1(WIDTH_RESET, MAX_WIDTH));
         hm1_ff       <= RW'(clamp_m1(HEIGHT_RESET, MAX_HEIGHT));
         ax_ff        <= '0;
         ay_ff        <= '0;
         ex_ff        <= '0;
         ey_ff        <= '0;
         full_ff      <= 1'b0;
         done_ff      <= 1'b0;
         pad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wm1_ff       <= wm1_in;
         hm1_ff       <= hm1_in;
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         ex_ff        <= ex_in;
         ey_ff        <= ey_in;
         full_ff      <= full_in;
         done_ff      <= done_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         p0_ff <= p0_in;
         pc_ff <= pc_in;
         pd_ff <= pd_in;
      end
      if (emit) begin
         blk_ff  <= blk;
         col_ff  <= COL_OUT_W'(ex0);
         row_ff  <= ROW_OUT_W'(ey0);
         last_ff <= last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_top_left      = blk_ff.top_left;
   assign rsp_top_right     = blk_ff.top_right;
   assign rsp_bottom_left   = blk_ff.bottom_left;
   assign rsp_bottom_right  = blk_ff.bottom_right;
   assign rsp_src_col       = col_ff;
   assign rsp_src_row       = row_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

@@ rtl/s2x_cell.sv @@
module s2x_cell
   import s2x_pkg::*;
(
   input  logic clock,
   input  logic shift,
   input  logic head,
   input  logic data_new,
   input  logic data_prev,
   output logic data_q
);

   logic data_ff;
   logic data_in;

   assign data_in = head ? data_new : data_prev;

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data_q = data_ff;

endmodule

@@ rtl/s2x_line.sv @@
module s2x_line
   import s2x_pkg::*;
#(
   parameter int DEPTH = MAX_WIDTH_DEF - 1,
   localparam int LW = $clog2(DEPTH + 1)
)
(
   input  logic          clock,
   input  logic          shift,
   input  logic [LW-1:0] len,
   input  logic          data_in,
   output logic          data_out
);

   logic [DEPTH-1:0] q;
   logic [DEPTH-1:0] head;

   // The newest pixel enters at the cell that leaves exactly len cells to the end.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      assign head[k] = (len == LW'(DEPTH - k));
      if (k == 0) begin : g_first
         s2x_cell u_cell (
            .clock     (clock),
            .shift     (shift),
            .head      (head[k]),
            .data_new  (data_in),
            .data_prev (data_in),
            .data_q    (q[k])
         );
      end else begin : g_rest
         s2x_cell u_cell (
            .clock     (clock),
            .shift     (shift),
            .head      (head[k]),
            .data_new  (data_in),
            .data_prev (q[k-1]),
            .data_q    (q[k])
         );
      end
   end

   assign data_out = (len == '0) ? data_in : q[DEPTH-1];

endmodule

@@ rtl/s2x_blend.sv @@
module s2x_blend
   import s2x_pkg::*;
(
   input  nbr_type nbr,
   output blk_type blk
);

   always_comb begin
      blk = '{top_left: nbr.e, top_right: nbr.e, bottom_left: nbr.e, bottom_right: nbr.e};
      if ((nbr.b != nbr.h) && (nbr.d != nbr.f)) begin
         blk.top_left     = (nbr.d == nbr.b) ? nbr.d : nbr.e;
         blk.top_right    = (nbr.b == nbr.f) ? nbr.f : nbr.e;
         blk.bottom_left  = (nbr.d == nbr.h) ? nbr.d : nbr.e;
         blk.bottom_right = (nbr.h == nbr.f) ? nbr.f : nbr.e;
      end
   end

endmodule

@@ rtl/s2x_checker.sv @@
module s2x_checker
   import s2x_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_top_left,
   input logic                 rsp_top_right,
   input logic                 rsp_bottom_left,
   input logic                 rsp_bottom_right,
   input logic [COL_OUT_W-1:0] rsp_src_col,
   input logic [ROW_OUT_W-1:0] rsp_src_row,
   input logic                 rsp_last_of_frame
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_top_left)
         && $stable(rsp_top_right) && $stable(rsp_bottom_left)
         && $stable(rsp_bottom_right) && $stable(rsp_src_col)
         && $stable(rsp_src_row) && $stable(rsp_last_of_frame))
      else $error("Stalled output word changed.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Output valid after reset.");

   a_no_extra_word: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall) && (!rsp_valid || !rsp_stall) |=> !rsp_valid)
      else $error("Output word appeared without an accepted input word.");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Input accepted while a stalled output word waits.");

endmodule

bind scale2x_pixel_upscaler s2x_checker u_s2x_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_top_left      (rsp_top_left),
   .rsp_top_right     (rsp_top_right),
   .rsp_bottom_left   (rsp_bottom_left),
   .rsp_bottom_right  (rsp_bottom_right),
   .rsp_src_col       (rsp_src_col),
   .rsp_src_row       (rsp_src_row),
   .rsp_last_of_frame (rsp_last_of_frame)
);
